@@ design/hbpf_pkg.sv @@
package hbpf_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 7;
  localparam int LEN_W       = 4;
  localparam int COUNT_W     = 4;
  localparam int TYPE_W      = 3;
  localparam int POS_W       = 3;
  localparam int HEAD_REG_W  = 42;
  localparam int LEN_REG_W   = 24;
  localparam int CFG_DATA_W  = 42;
  localparam int CFG_IDX_W   = 1;
  localparam int TABLE_SLOTS = 8;
  localparam int MIN_LEN     = 2;
  // frame length minus the data bytes: head, high-bits byte and checksum
  localparam int OVERHEAD    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_CODES    = 1'b0,
    REG_FRAME_LENGTHS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

@@ design/hbpf_if.sv @@
interface hbpf_rx_if;
  import hbpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hbpf_res_if;
  import hbpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] frame_type;
  logic [POS_W-1:0]  position;
  logic [BYTE_W-1:0] value;
  logic              last;

  modport source (output valid, output frame_type, output position, output value,
                  output last, input ready);
  modport sink (input valid, input frame_type, input position, input value,
                input last, output ready);
endinterface

@@ design/high_bit_packed_frame_receiver.sv @@
// channel  dir  fields                                    handshake
// rx       in   rx_byte[7:0]                              valid/ready
// res      out  frame_type[2:0] position[2:0] value[7:0]  valid/ready
//              last
// cfg      in   cfg_index[0] cfg_data[41:0]               cfg_wr_en, no back-pressure
//
// one byte is taken per cycle; a good checksum byte queues one frame record
// a frame of length L gives L-2 results (one for length 2), one per cycle from
// the result register while res.ready stays high
// rx stalls only while the two-entry frame queue is full
// the first result of a frame follows its checksum byte through the frame queue and the result register
// synchronous reset clears the frame state, the queue and both registers
module high_bit_packed_frame_receiver #(
  parameter int NUM_TYPES = 6,
  parameter int MAX_DATA  = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [hbpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  hbpf_rx_if.sink                          rx,
  hbpf_res_if.source                       res
);
  import hbpf_pkg::*;

  localparam int REC_W   = TYPE_W + CODE_W + POS_W + MAX_DATA + MAX_DATA * CODE_W;
  localparam int Q_DEPTH = 2;

  cfg_wr_t          cfg;
  logic             rec_push;
  logic [REC_W-1:0] rec_in;
  logic             rec_full;
  logic             rec_pop;
  logic             rec_valid;
  logic [REC_W-1:0] rec_out;

  assign cfg = '{wr_en: cfg_wr_en, index: cfg_index, data: cfg_data};

  hbpf_front #(
    .NUM_TYPES (NUM_TYPES),
    .MAX_DATA  (MAX_DATA)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx       (rx),
    .rec_push (rec_push),
    .rec_data (rec_in),
    .rec_full (rec_full)
  );

  hbpf_fifo #(
    .WIDTH (REC_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (rec_push),
    .push_data  (rec_in),
    .full       (rec_full),
    .pop        (rec_pop),
    .head_valid (rec_valid),
    .head_data  (rec_out)
  );

  hbpf_back #(
    .MAX_DATA (MAX_DATA)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_data  (rec_out),
    .rec_pop   (rec_pop),
    .res       (res)
  );

endmodule

@@ design/hbpf_front.sv @@
module hbpf_front #(
  parameter int NUM_TYPES = 6,
  parameter int MAX_DATA  = 7,
  localparam int REC_W    = hbpf_pkg::TYPE_W + hbpf_pkg::CODE_W + hbpf_pkg::POS_W
                            + MAX_DATA + MAX_DATA * hbpf_pkg::CODE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  hbpf_pkg::cfg_wr_t cfg,
  hbpf_rx_if.sink           rx,
  output logic              rec_push,
  output logic [REC_W-1:0]  rec_data,
  input  logic              rec_full
);
  import hbpf_pkg::*;

  localparam int LEN_MAX = MAX_DATA + OVERHEAD;

  logic [HEAD_REG_W-1:0] head_codes;
  logic [LEN_REG_W-1:0]  frame_lengths;
  logic                  in_frame;
  logic [TYPE_W-1:0]     entry_index;
  logic [COUNT_W-1:0]    byte_count;
  logic [CODE_W-1:0]     running_sum;
  logic [MAX_DATA-1:0]   high_bits;
  logic [CODE_W-1:0]     data_store [MAX_DATA];

  logic [TABLE_SLOTS*CODE_W-1:0] codes_ext;
  logic [TABLE_SLOTS*LEN_W-1:0]  lens_ext;
  logic [BYTE_W-1:0]             b;
  logic                          accept;
  logic [LEN_W-1:0]              cur_len;
  logic                          cur_en;
  logic                          frame_byte;
  logic                          is_check;
  logic                          found;
  logic [TYPE_W-1:0]             found_idx;
  logic [LEN_W-1:0]              ndata_full;
  logic [POS_W-1:0]              ndata;
  logic [MAX_DATA*CODE_W-1:0]    data_flat;

  // table slots beyond the register width read as code 0 and length 0
  assign codes_ext = {(TABLE_SLOTS*CODE_W-HEAD_REG_W)'(0), head_codes};
  assign lens_ext  = {(TABLE_SLOTS*LEN_W-LEN_REG_W)'(0), frame_lengths};

  assign b        = rx.rx_byte;
  assign rx.ready = !rec_full;
  assign accept   = rx.valid && rx.ready;

  assign cur_len    = lens_ext[entry_index*LEN_W +: LEN_W];
  assign cur_en     = (cur_len >= LEN_W'(MIN_LEN)) && (cur_len <= LEN_W'(LEN_MAX));
  assign frame_byte = in_frame && cur_en && b[BYTE_W-1];
  assign is_check   = ({1'b0, byte_count} + 5'd1) >= {1'b0, cur_len};

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    // walk downwards so the lowest matching entry wins
    for (int k = NUM_TYPES - 1; k >= 0; k--) begin
      if ((lens_ext[k*LEN_W +: LEN_W] >= LEN_W'(MIN_LEN)) &&
          (lens_ext[k*LEN_W +: LEN_W] <= LEN_W'(LEN_MAX)) &&
          (codes_ext[k*CODE_W +: CODE_W] == b[CODE_W-1:0])) begin
        found     = 1'b1;
        found_idx = TYPE_W'(k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DATA; i++) begin
      data_flat[i*CODE_W +: CODE_W] = data_store[i];
    end
  end

  assign ndata_full = (cur_len > LEN_W'(MIN_LEN)) ? cur_len - LEN_W'(OVERHEAD) : '0;
  assign ndata      = ndata_full[POS_W-1:0];

  assign rec_push = accept && frame_byte && is_check && (running_sum == b[CODE_W-1:0]);
  assign rec_data = {entry_index, codes_ext[entry_index*CODE_W +: CODE_W], ndata,
                     high_bits, data_flat};

  always_ff @(posedge clk) begin
    if (rst) begin
      head_codes    <= '0;
      frame_lengths <= '0;
      in_frame      <= 1'b0;
      entry_index   <= '0;
      byte_count    <= '0;
      running_sum   <= '0;
      high_bits     <= '0;
    end else begin
      if (cfg.wr_en) begin
        case (cfg_reg_t'(cfg.index))
          REG_HEAD_CODES:    head_codes    <= cfg.data[HEAD_REG_W-1:0];
          REG_FRAME_LENGTHS: frame_lengths <= cfg.data[LEN_REG_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_byte) begin
          if (is_check) begin
            in_frame <= 1'b0;
          end else begin
            running_sum <= running_sum + b[CODE_W-1:0];
            byte_count  <= byte_count + COUNT_W'(1);
            if (byte_count == COUNT_W'(1)) begin
              high_bits <= b[MAX_DATA-1:0];
            end
          end
        end else begin
          // idle, or an abort: the byte is tried as a head
          in_frame <= 1'b0;
          if (!b[BYTE_W-1] && found) begin
            in_frame    <= 1'b1;
            entry_index <= found_idx;
            byte_count  <= COUNT_W'(1);
            running_sum <= b[CODE_W-1:0];
            high_bits   <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DATA; i++) begin
      if (accept && frame_byte && !is_check && (byte_count == COUNT_W'(i + 2))) begin
        data_store[i] <= b[CODE_W-1:0];
      end
    end
  end

endmodule

@@ design/hbpf_fifo.sv @@
module hbpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

@@ design/hbpf_back.sv @@
module hbpf_back #(
  parameter int MAX_DATA = 7,
  localparam int REC_W   = hbpf_pkg::TYPE_W + hbpf_pkg::CODE_W + hbpf_pkg::POS_W
                           + MAX_DATA + MAX_DATA * hbpf_pkg::CODE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rec_valid,
  input  logic [REC_W-1:0] rec_data,
  output logic             rec_pop,
  hbpf_res_if.source       res
);
  import hbpf_pkg::*;

  logic [TYPE_W-1:0]          r_type;
  logic [CODE_W-1:0]          r_code;
  logic [POS_W-1:0]           r_ndata;
  logic [MAX_DATA-1:0]        r_high;
  logic [MAX_DATA*CODE_W-1:0] r_data;
  logic [POS_W-1:0]           pos;
  logic                       load;
  logic                       is_last;
  logic [BYTE_W-1:0]          val;

  assign {r_type, r_code, r_ndata, r_high, r_data} = rec_data;

  assign load    = rec_valid && (!res.valid || res.ready);
  assign is_last = (pos == r_ndata);
  assign rec_pop = load && is_last;

  always_comb begin
    val = {1'b0, r_code};
    for (int i = 0; i < MAX_DATA; i++) begin
      if (pos == POS_W'(i + 1)) begin
        val = {r_high[i], r_data[i*CODE_W +: CODE_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        res.valid <= 1'b1;
        pos       <= is_last ? '0 : pos + POS_W'(1);
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.frame_type <= r_type;
      res.position   <= pos;
      res.value      <= val;
      res.last       <= is_last;
    end
  end

endmodule

@@ test/hbpf_result_check.sv @@
module hbpf_result_check #(
  parameter int NUM_TYPES = 6,
  parameter int MAX_DATA  = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [hbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbpf_pkg::CFG_DATA_W-1:0] cfg_data,
  hbpf_rx_if                              rx,
  hbpf_res_if                             res,
  output int                              mismatches,
  output int                              pending
);
  import hbpf_pkg::*;

  typedef struct packed {
    logic [TYPE_W-1:0] frame_type;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic              last;
  } frame_result_t;

  frame_result_t results_due[$];

  // register copies and frame state
  logic [HEAD_REG_W-1:0] head_reg;
  logic [LEN_REG_W-1:0]  len_reg;
  logic                  in_frame;
  logic [TYPE_W-1:0]     entry_sel;
  logic [COUNT_W-1:0]    bytes_seen;
  logic [CODE_W-1:0]     sum7;
  logic [BYTE_W-1:0]     high_bits;
  logic [CODE_W-1:0]     data_seen [MAX_DATA];

  initial mismatches = 0;
  initial pending = 0;

  function automatic int entry_len(input int k);
    int n;
    if (k >= NUM_TYPES || k >= TABLE_SLOTS || 4 * k + LEN_W > LEN_REG_W) return 0;
    n = int'(len_reg[4 * k +: LEN_W]);
    return (n >= MIN_LEN && n <= MAX_DATA + OVERHEAD) ? n : 0;
  endfunction

  function automatic logic [CODE_W-1:0] entry_code(input int k);
    if (k >= TABLE_SLOTS || 7 * k + CODE_W > HEAD_REG_W) return '0;
    return head_reg[7 * k +: CODE_W];
  endfunction

  // lowest matching enabled entry, or -1
  function automatic int match_head(input logic [CODE_W-1:0] code);
    for (int k = 0; k < NUM_TYPES && k < TABLE_SLOTS; k++)
      if (entry_len(k) != 0 && entry_code(k) == code) return k;
    return -1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic receive_byte(input logic [BYTE_W-1:0] b);
    int len;
    int n_data;
    int hit;
    bit try_head;
    frame_result_t r;
    try_head = 1'b1;
    if (in_frame) begin
      len = entry_len(entry_sel);
      if (len == 0 || !b[7]) begin
        // aborted: the byte falls through to the idle handling
        in_frame = 1'b0;
      end else begin
        try_head = 1'b0;
        if (int'(bytes_seen) + 1 >= len) begin
          in_frame = 1'b0;
          if (sum7 == b[CODE_W-1:0]) begin
            n_data = (len > MIN_LEN) ? len - OVERHEAD : 0;
            if (n_data > MAX_DATA) n_data = MAX_DATA;
            r.frame_type = entry_sel;
            r.position   = '0;
            r.value      = {1'b0, entry_code(entry_sel)};
            r.last       = (n_data == 0);
            results_due.push_back(r);
            for (int i = 0; i < n_data; i++) begin
              r.position = POS_W'(i + 1);
              r.value    = {high_bits[i], data_seen[i]};
              r.last     = (i + 1 == n_data);
              results_due.push_back(r);
            end
          end
        end else begin
          sum7 = sum7 + b[CODE_W-1:0];
          if (bytes_seen == 1) begin
            high_bits = b;
          end else if (bytes_seen >= 2 && int'(bytes_seen) - 2 < MAX_DATA) begin
            data_seen[bytes_seen - 2] = b[CODE_W-1:0];
          end
          bytes_seen = bytes_seen + 1'b1;
        end
      end
    end
    if (try_head && !b[7]) begin
      hit = match_head(b[CODE_W-1:0]);
      if (hit >= 0) begin
        in_frame   = 1'b1;
        entry_sel  = TYPE_W'(hit);
        bytes_seen = 1;
        sum7       = b[CODE_W-1:0];
        high_bits  = '0;
      end
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (results_due.size() == 0) begin
      report($sformatf("result with nothing due: type %0d pos %0d value %02h last %0b",
                       res.frame_type, res.position, res.value, res.last));
    end else begin
      want = results_due.pop_front();
      if (res.frame_type !== want.frame_type)
        report($sformatf("frame_type %0d, expected %0d", res.frame_type, want.frame_type));
      if (res.position !== want.position)
        report($sformatf("position %0d, expected %0d", res.position, want.position));
      if (res.value !== want.value)
        report($sformatf("value %02h, expected %02h", res.value, want.value));
      if (res.last !== want.last)
        report($sformatf("last %0b, expected %0b", res.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_reg   = '0;
      len_reg    = '0;
      in_frame   = 1'b0;
      entry_sel  = '0;
      bytes_seen = '0;
      sum7       = '0;
      high_bits  = '0;
      foreach (data_seen[i]) data_seen[i] = '0;
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEAD_CODES:    head_reg = cfg_data[HEAD_REG_W-1:0];
          REG_FRAME_LENGTHS: len_reg  = cfg_data[LEN_REG_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) check_result();
      if (rx.valid && rx.ready) receive_byte(rx.rx_byte);
    end
    pending = results_due.size();
  end
endmodule

@@ test/high_bit_packed_frame_receiver_tb.sv @@
module high_bit_packed_frame_receiver_tb;
  import hbpf_pkg::*;

  localparam int NUM_TYPES   = 6;
  localparam int MAX_DATA    = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int PHASE_BYTES = 34;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_RANDOM,
    SINK_SPARSE,
    SINK_BURSTY
  } stall_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hbpf_rx_if  rx ();
  hbpf_res_if res ();

  int mismatches;
  int pending;

  // stimulus-side view of the registers
  logic [HEAD_REG_W-1:0] cur_heads;
  logic [LEN_REG_W-1:0]  cur_lens;
  logic [BYTE_W-1:0]     pkt[$];
  int                    burst_left = 0;
  int                    bytes_sent = 0;
  int                    cycle_count = 0;
  logic [31:0]           sink_tick = '0;
  stall_mode_t           sink_mode = SINK_FREE;

  high_bit_packed_frame_receiver #(
    .NUM_TYPES (NUM_TYPES),
    .MAX_DATA  (MAX_DATA)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res)
  );

  hbpf_result_check #(
    .NUM_TYPES (NUM_TYPES),
    .MAX_DATA  (MAX_DATA)
  ) result_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx),
    .res        (res),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: drives res.ready in one of four stall patterns, redrawn at random
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (sink_tick % 50 == 0) sink_mode <= stall_mode_t'($urandom_range(0, 3));
    case (sink_mode)
      SINK_FREE:   res.ready <= 1'b1;
      SINK_RANDOM: res.ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: res.ready <= (sink_tick[1:0] == 2'd0);
      default:     res.ready <= (sink_tick[3:0] >= 4'd10);
    endcase
  end

  function automatic int frame_len(input int k);
    int n;
    n = int'(cur_lens[4 * k +: LEN_W]);
    return (n >= MIN_LEN && n <= MAX_DATA + OVERHEAD) ? n : 0;
  endfunction

  // a 7-bit byte that opens no frame under the current table
  function automatic logic [BYTE_W-1:0] quiet_byte();
    bit taken;
    for (int v = 0; v < 128; v++) begin
      taken = 1'b0;
      for (int k = 0; k < NUM_TYPES; k++)
        if (frame_len(k) != 0 && cur_heads[7 * k +: CODE_W] == CODE_W'(v)) taken = 1'b1;
      if (!taken) return BYTE_W'(v);
    end
    return '0;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // sends the packet, with a checksum byte appended when sealed,
  // otherwise only its first keep bytes
  task automatic send_pkt(input bit seal, input bit good_sum, input int keep);
    logic [CODE_W-1:0] total;
    int n;
    n = keep;
    if (seal) begin
      total = '0;
      foreach (pkt[j]) total = total + pkt[j][CODE_W-1:0];
      if (!good_sum) total = total ^ CODE_W'($urandom_range(1, 127));
      pkt.push_back({1'b1, total});
      n = pkt.size();
    end
    for (int i = 0; i < n && i < pkt.size(); i++) send_byte(pkt[i]);
    pkt.delete();
  endtask

  task automatic random_frame(input int k, input bit good_sum, input bit cut);
    int len;
    len = frame_len(k);
    pkt.delete();
    pkt.push_back({1'b0, cur_heads[7 * k +: CODE_W]});
    for (int j = 1; j < len - 1; j++) pkt.push_back(8'h80 | BYTE_W'($urandom_range(0, 127)));
    if (cut) send_pkt(1'b0, 1'b0, $urandom_range(1, len - 1));
    else send_pkt(1'b1, good_sum, 0);
  endtask

  task automatic write_config(input logic [HEAD_REG_W-1:0] heads,
                              input logic [LEN_REG_W-1:0] lens);
    logic [63:0] filler;
    filler    = {$urandom, $urandom};
    cur_heads = heads;
    cur_lens  = lens;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HEAD_CODES;
    cfg_data  <= heads;
    @(posedge clk);
    // spare upper bits of the length write are don't-care
    cfg_index <= REG_FRAME_LENGTHS;
    cfg_data  <= {filler[CFG_DATA_W-LEN_REG_W-1:0], lens};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // close any half-open frame, then drain before the registers change
  task automatic finish_phase();
    send_byte(quiet_byte());
    rx.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [63:0]           r;
    logic [HEAD_REG_W-1:0] heads;
    logic [LEN_REG_W-1:0]  lens;
    int                    enabled[$];
    int                    choice;
    int                    w;

    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_HEAD_CODES;
    cfg_data   <= '0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // entry 5 shares code 00 with entry 0; entry 4 has a disabled length
    write_config({7'h00, 7'h01, 7'h2A, 7'h55, 7'h7F, 7'h00},
                 {4'd3, 4'd11, 4'd5, 4'd3, 4'd10, 4'd2});
    pkt = '{8'h00};
    send_pkt(1'b1, 1'b1, 0);
    pkt = '{8'h7F, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF, 8'h80, 8'hFF};
    send_pkt(1'b1, 1'b1, 0);
    pkt = '{8'h2A, 8'h80, 8'hFF, 8'h80};
    send_pkt(1'b1, 1'b1, 0);
    pkt = '{8'h55, 8'hA5};
    send_pkt(1'b1, 1'b0, 0);
    // frame cut short by a new head
    pkt = '{8'h2A, 8'h81};
    send_pkt(1'b0, 1'b0, 2);
    pkt = '{8'h55, 8'hC0};
    send_pkt(1'b1, 1'b1, 0);
    // disabled head, then an idle byte with bit 7 set
    pkt = '{8'h01, 8'h81};
    send_pkt(1'b0, 1'b0, 2);
    finish_phase();

    for (int ph = 1; ph <= 8; ph++) begin
      r     = {$urandom, $urandom};
      heads = r[HEAD_REG_W-1:0];
      lens  = '0;
      case (ph)
        1: begin
          heads = '1;
          lens  = 24'hAAAAAA;
        end
        2: begin
          heads = '0;
          lens  = 24'h222222;
        end
        3: lens = 24'hFFFFFF;
        default: begin
          for (int k = 0; k < NUM_TYPES; k++) begin
            w = $urandom_range(0, 6);
            lens[4 * k +: LEN_W] = ($urandom_range(0, 9) < 8) ?
                                   LEN_W'($urandom_range(2, 10)) :
                                   LEN_W'(w < 2 ? w : w + 9);
          end
        end
      endcase
      write_config(heads, lens);
      enabled.delete();
      for (int k = 0; k < NUM_TYPES; k++)
        if (frame_len(k) != 0) enabled.push_back(k);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        choice = $urandom_range(0, 99);
        if (enabled.size() == 0 || choice >= 85) begin
          send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
          random_frame(enabled[$urandom_range(0, enabled.size() - 1)],
                       $urandom_range(0, 7) != 0, choice >= 72);
        end
      end
      finish_phase();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
